[hw/rtl/rsr_pkg.sv]
// ---------------------------------------------------------------------------
// rsr_pkg: shared types and constants for the rlc sdu reassembly block
// beat payloads, event codes, per-item result record and register map
// ---------------------------------------------------------------------------
package rsr_pkg;

  localparam int unsigned SDU_BUFFER_BYTES = 8192;
  localparam int unsigned LEN_W            = 14;
  localparam int unsigned OFF_W            = 13;
  localparam int unsigned CFG_ADDR_W       = 2;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam int unsigned MAX_RES          = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_SDU_LIMIT   = CFG_ADDR_W'(0);
  localparam logic [LEN_W-1:0]      SDU_LIMIT_RESET = LEN_W'(8192);
  localparam logic [LEN_W-1:0]      BUF_CAP         = LEN_W'(SDU_BUFFER_BYTES);

  typedef enum logic [1:0] {
    EV_WRITE    = 2'd0,
    EV_DELIVER  = 2'd1,
    EV_OVERFLOW = 2'd2,
    EV_EMPTY    = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             pdu_first;
    logic             seg_start;
    logic             seg_end;
    logic [LEN_W-1:0] seg_length;
    logic             seg_from_li;
    logic             data_starts_sdu;
    logic             data_ends_sdu;
  } in_item_t;

  typedef struct packed {
    ev_kind_t         event_kind;
    logic [7:0]       out_byte;
    logic [OFF_W-1:0] write_offset;
    logic [LEN_W-1:0] sdu_length;
    logic             last_of_run;
  } out_item_t;

  // all results caused by one input beat, packed to the low slots
  typedef struct packed {
    out_item_t [MAX_RES-1:0] slot;
    logic [1:0]              n;
  } rec_t;

endpackage

[hw/rtl/rsr_step.sv]
// ---------------------------------------------------------------------------
// rsr_step: per-beat reassembly decision
// holds fill count, open and discard flags; builds the result record of a beat
// ---------------------------------------------------------------------------
module rsr_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  rsr_pkg::in_item_t             item,
  input  logic [rsr_pkg::LEN_W-1:0]     lim,
  output rsr_pkg::rec_t                 rec
);

  logic [rsr_pkg::LEN_W-1:0] fill_r, fill_nxt;
  logic                      open_r, open_nxt;
  logic                      disc_r, disc_nxt;

  always_comb begin
    logic [rsr_pkg::LEN_W-1:0] fc;
    logic                      op;
    logic                      dsc;
    logic [rsr_pkg::LEN_W:0]   sum;
    logic                      va, vm, vd;
    rsr_pkg::out_item_t        ra, rm, rd;

    fc  = fill_r;
    op  = open_r;
    dsc = disc_r;
    va  = 1'b0;
    vm  = 1'b0;
    vd  = 1'b0;
    ra  = '0;
    rm  = '0;
    rd  = '0;
    sum = '0;

    // pending delivery at the start of a pdu whose data opens an sdu
    if (item.seg_start && item.pdu_first && item.data_starts_sdu && op) begin
      va = 1'b1;
      if (fc != '0) begin
        ra.event_kind = rsr_pkg::EV_DELIVER;
        ra.sdu_length = fc;
        op = 1'b0;
      end else begin
        ra.event_kind = rsr_pkg::EV_EMPTY;
      end
      fc = '0;
    end

    // segment admission check
    if (item.seg_start) begin
      if (!op) begin
        op = 1'b1;
        fc = '0;
      end
      sum = {1'b0, fc} + {1'b0, item.seg_length};
      if (sum <= {1'b0, lim}) begin
        dsc = 1'b0;
      end else begin
        dsc = 1'b1;
        fc  = '0;
        vm  = 1'b1;
        rm.event_kind = rsr_pkg::EV_OVERFLOW;
      end
    end

    // byte write, excess bytes past the limit are dropped silently
    if (!dsc) begin
      if (!op) begin
        op = 1'b1;
        fc = '0;
      end
      if (fc < lim) begin
        vm = 1'b1;
        rm.event_kind   = rsr_pkg::EV_WRITE;
        rm.out_byte     = item.data_byte;
        rm.write_offset = fc[rsr_pkg::OFF_W-1:0];
        fc = fc + rsr_pkg::LEN_W'(1);
      end
    end

    // segment end delivery
    if (item.seg_end) begin
      dsc = 1'b0;
      if ((item.seg_from_li || item.data_ends_sdu) && op) begin
        vd = 1'b1;
        if (fc != '0) begin
          rd.event_kind = rsr_pkg::EV_DELIVER;
          rd.sdu_length = fc;
          op = 1'b0;
        end else begin
          rd.event_kind = rsr_pkg::EV_EMPTY;
        end
        fc = '0;
      end
    end

    fill_nxt = fc;
    open_nxt = op;
    disc_nxt = dsc;

    rec.slot[0] = va ? ra : (vm ? rm : rd);
    rec.slot[1] = va ? (vm ? rm : rd) : rd;
    rec.slot[2] = rd;
    rec.n       = 2'(va) + 2'(vm) + 2'(vd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      open_r <= 1'b0;
      disc_r <= 1'b0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      open_r <= open_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

[hw/rtl/rsr_evq.sv]
// ---------------------------------------------------------------------------
// rsr_evq: two-record result queue
// stores per-beat result records and hands them out one result per beat
// ---------------------------------------------------------------------------
module rsr_evq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rsr_pkg::rec_t       rec_in,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output rsr_pkg::out_item_t  out_data
);

  rsr_pkg::rec_t rec_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic [1:0]    idx_r, idx_nxt;
  rsr_pkg::rec_t head;
  logic          last;
  logic          fire;
  logic          pop;

  assign head      = rec_r[rd_ptr_r];
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign last      = (idx_r == (head.n - 2'd1));
  assign fire      = out_valid && out_ready;
  assign pop       = fire && last;

  always_comb begin
    out_data             = head.slot[idx_r];
    out_data.last_of_run = last;
  end

  always_comb begin
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    idx_nxt    = idx_r;
    if (fire) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      idx_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rec_r[wr_ptr_r] <= rec_in;
    end
  end

endmodule

[hw/rtl/rlc_sdu_reassembly_top.sv]
// ---------------------------------------------------------------------------
// rlc_sdu_reassembly_top: byte-serial sdu reassembly from rlc pdu payload
// per-byte buffer writes, sdu deliveries, overflow and empty-sdu events
// ---------------------------------------------------------------------------
// One payload byte is taken per beat, tagged with its segment boundaries and
// its pdu's framing flags. Each byte produces zero to three result beats in
// order: a pending delivery, then an overflow event or a byte write with its
// buffer offset, then a delivery at segment end; last_of_run marks the final
// result of a byte. The decision for a byte is made in the cycle it is
// accepted and, if it yields results, stored as one record in a two-record
// queue, so bytes with one result each sustain one byte per cycle while
// out_ready stays high; a byte with several results hands them out in turn,
// and the input stalls only when both records are still waiting. sdu_limit
// (register 0, byte address 0) sets the largest sdu in bytes, capped at the
// 8192-byte buffer; write it only while the block is idle.
module rlc_sdu_reassembly_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input beats
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rsr_pkg::in_item_t                   in_data,
  // result beats
  output logic                                out_valid,
  input  logic                                out_ready,
  output rsr_pkg::out_item_t                  out_data,
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rsr_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [rsr_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [rsr_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  logic [rsr_pkg::LEN_W-1:0] sdu_limit_r;
  logic [rsr_pkg::LEN_W-1:0] lim;
  logic                      cfg_wr;
  logic                      in_fire;
  logic                      q_full;
  rsr_pkg::rec_t             rec;

  // ---- configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sdu_limit_r <= rsr_pkg::SDU_LIMIT_RESET;
    end else if (cfg_wr && (cfg_paddr == rsr_pkg::REG_SDU_LIMIT)) begin
      sdu_limit_r <= cfg_pwdata[rsr_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      rsr_pkg::REG_SDU_LIMIT: cfg_prdata = rsr_pkg::CFG_DATA_W'(sdu_limit_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // limit in force never exceeds the buffer size
  assign lim = (sdu_limit_r > rsr_pkg::BUF_CAP) ? rsr_pkg::BUF_CAP : sdu_limit_r;

  // ---- input side: accept whenever the queue has a free record
  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  rsr_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_fire),
    .item   (in_data),
    .lim    (lim),
    .rec    (rec)
  );

  // ---- result side: bytes with no result push nothing
  rsr_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && (rec.n != 2'd0)),
    .rec_in    (rec),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ---- checks

  // a stalled input means results are pending
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result queue");

  // delivered sdus are never empty and never exceed the buffer
  a_deliver_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.event_kind == rsr_pkg::EV_DELIVER)) |->
      ((out_data.sdu_length != '0) && (out_data.sdu_length <= rsr_pkg::BUF_CAP)))
    else $error("delivered sdu length out of range");

  // a byte write never lands at or past the limit in force
  a_write_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.event_kind == rsr_pkg::EV_WRITE)) |->
      ({1'b0, out_data.write_offset} < lim))
    else $error("byte written beyond sdu limit");

endmodule
